// File: rtl/r2h_pkg.sv
// ----------------------------------------------------------------------------
// r2h_pkg: shared types and constants for the RGB to HSV converter
// Field widths, hue sector offsets and the stage payload structs.
// ----------------------------------------------------------------------------
package r2h_pkg;

  localparam int CH_W   = 8;   // colour channel width
  localparam int HUE_W  = 15;  // hue width, 1/64 degree units
  localparam int Q_W    = 12;  // quotient bits of both divisions
  localparam int DIVD_W = 20;  // dividend width, 8 bit head plus Q_W tail
  localparam int STEP_N = 4;   // quotient bits resolved per divider stage

  localparam logic [DIVD_W-1:0] HUE_SECTOR = 20'd3840;
  localparam logic [DIVD_W-1:0] SAT_SCALE  = 20'd255;

  localparam logic [15:0] HUE_OFS_RED   = 16'd0;
  localparam logic [15:0] HUE_OFS_GREEN = 16'd7680;
  localparam logic [15:0] HUE_OFS_BLUE  = 16'd15360;
  localparam logic [15:0] HUE_FULL      = 16'd23040;

  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  // after the range stage
  typedef struct packed {
    logic            grey;
    logic            neg;
    logic [1:0]      sector;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] delta;
    logic [CH_W-1:0] absnum;
  } front_t;

  // divider lane: hue divides by delta, saturation by max
  typedef struct packed {
    logic            grey;
    logic            neg;
    logic [1:0]      sector;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] delta;
    logic [CH_W-1:0] rem_h;
    logic [CH_W-1:0] rem_s;
    logic [Q_W-1:0]  xh;
    logic [Q_W-1:0]  xs;
    logic [Q_W-1:0]  qh;
    logic [Q_W-1:0]  qs;
  } div_t;

endpackage

// File: rtl/r2h_if.sv
// ----------------------------------------------------------------------------
// r2h_if: request channels of the RGB to HSV converter
// Pixel channel in, HSV channel out, each with valid/ready.
// ----------------------------------------------------------------------------
interface r2h_pix_if;
  logic                     valid;
  logic                     ready;
  logic [r2h_pkg::CH_W-1:0] red;
  logic [r2h_pkg::CH_W-1:0] green;
  logic [r2h_pkg::CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface r2h_hsv_if;
  logic                      valid;
  logic                      ready;
  logic [r2h_pkg::HUE_W-1:0] hue;
  logic [r2h_pkg::CH_W-1:0]  saturation;
  logic [r2h_pkg::CH_W-1:0]  brightness;
  logic                      grey;

  modport source (output valid, hue, saturation, brightness, grey, input ready);
  modport sink   (input valid, hue, saturation, brightness, grey, output ready);
endinterface

// File: rtl/r2h_front.sv
// ----------------------------------------------------------------------------
// r2h_front: range and dividend stages
// Finds max, min, delta and hue sector, then forms both dividends.
// ----------------------------------------------------------------------------
module r2h_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [r2h_pkg::CH_W-1:0]  red,
  input  logic [r2h_pkg::CH_W-1:0]  green,
  input  logic [r2h_pkg::CH_W-1:0]  blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output r2h_pkg::div_t             out_data
);

  logic             v1;
  r2h_pkg::front_t  s1;
  r2h_pkg::front_t  s1_next;
  logic             ready2;
  r2h_pkg::div_t    s2_next;

  logic [r2h_pkg::CH_W-1:0]   mx;
  logic [r2h_pkg::CH_W-1:0]   mn;
  logic [r2h_pkg::CH_W:0]     diff;
  logic [r2h_pkg::DIVD_W-1:0] hx;
  logic [r2h_pkg::DIVD_W-1:0] sx;

  assign ready2   = !out_valid || out_ready;
  assign in_ready = !v1 || ready2;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;

    // red wins ties, then green
    priority if (red >= mx) begin
      diff             = {1'b0, green} - {1'b0, blue};
      s1_next.sector   = r2h_pkg::SECT_RED;
    end else if (green >= mx) begin
      diff             = {1'b0, blue} - {1'b0, red};
      s1_next.sector   = r2h_pkg::SECT_GREEN;
    end else begin
      diff             = {1'b0, red} - {1'b0, green};
      s1_next.sector   = r2h_pkg::SECT_BLUE;
    end

    s1_next.mx     = mx;
    s1_next.delta  = mx - mn;
    s1_next.grey   = (mx == mn);
    s1_next.neg    = diff[r2h_pkg::CH_W];
    s1_next.absnum = diff[r2h_pkg::CH_W] ? 8'(-diff) : diff[r2h_pkg::CH_W-1:0];
  end

  always_comb begin
    hx = {12'd0, s1.absnum} * r2h_pkg::HUE_SECTOR;
    sx = {12'd0, s1.delta} * r2h_pkg::SAT_SCALE;
    s2_next.grey   = s1.grey;
    s2_next.neg    = s1.neg;
    s2_next.sector = s1.sector;
    s2_next.mx     = s1.mx;
    s2_next.delta  = s1.delta;
    // dividend heads already lie below their divisors
    s2_next.rem_h  = hx[r2h_pkg::DIVD_W-1:r2h_pkg::Q_W];
    s2_next.rem_s  = sx[r2h_pkg::DIVD_W-1:r2h_pkg::Q_W];
    s2_next.xh     = hx[r2h_pkg::Q_W-1:0];
    s2_next.xs     = sx[r2h_pkg::Q_W-1:0];
    s2_next.qh     = '0;
    s2_next.qs     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (ready2)   out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1 <= s1_next;
    if (ready2 && v1)         out_data <= s2_next;
  end

endmodule

// File: rtl/r2h_div_stage.sv
// ----------------------------------------------------------------------------
// r2h_div_stage: one stage of the restoring divider lane
// Resolves four quotient bits of the hue and saturation divisions.
// ----------------------------------------------------------------------------
module r2h_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  r2h_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output r2h_pkg::div_t out_data
);

  r2h_pkg::div_t nxt;
  logic [r2h_pkg::CH_W:0] trial_h;
  logic [r2h_pkg::CH_W:0] trial_s;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    nxt     = in_data;
    trial_h = '0;
    trial_s = '0;
    for (int i = 0; i < r2h_pkg::STEP_N; i++) begin
      trial_h = {nxt.rem_h, nxt.xh[r2h_pkg::Q_W-1]};
      trial_s = {nxt.rem_s, nxt.xs[r2h_pkg::Q_W-1]};
      nxt.xh  = {nxt.xh[r2h_pkg::Q_W-2:0], 1'b0};
      nxt.xs  = {nxt.xs[r2h_pkg::Q_W-2:0], 1'b0};
      if (trial_h >= {1'b0, nxt.delta}) begin
        trial_h = trial_h - {1'b0, nxt.delta};
        nxt.qh  = {nxt.qh[r2h_pkg::Q_W-2:0], 1'b1};
      end else begin
        nxt.qh  = {nxt.qh[r2h_pkg::Q_W-2:0], 1'b0};
      end
      if (trial_s >= {1'b0, nxt.mx}) begin
        trial_s = trial_s - {1'b0, nxt.mx};
        nxt.qs  = {nxt.qs[r2h_pkg::Q_W-2:0], 1'b1};
      end else begin
        nxt.qs  = {nxt.qs[r2h_pkg::Q_W-2:0], 1'b0};
      end
      nxt.rem_h = trial_h[r2h_pkg::CH_W-1:0];
      nxt.rem_s = trial_s[r2h_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) out_data <= nxt;
  end

`ifndef SYNTHESIS
  a_rem_h_below_divisor: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.grey |-> out_data.rem_h < out_data.delta)
    else $error("hue remainder not below delta");

  a_rem_s_below_divisor: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.grey |-> out_data.rem_s < out_data.mx)
    else $error("saturation remainder not below max");
`endif

endmodule

// File: rtl/r2h_hue_fix.sv
// ----------------------------------------------------------------------------
// r2h_hue_fix: hue sign, sector offset and output register
// Floors negative hue quotients, adds the sector offset and wraps.
// ----------------------------------------------------------------------------
module r2h_hue_fix (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  r2h_pkg::div_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [r2h_pkg::HUE_W-1:0]  hue,
  output logic [r2h_pkg::CH_W-1:0]   saturation,
  output logic [r2h_pkg::CH_W-1:0]   brightness,
  output logic                       grey
);

  logic [r2h_pkg::Q_W:0] qmag;
  logic [15:0]           ofs;
  logic [15:0]           hsum;
  logic [15:0]           hwrap;
  logic [r2h_pkg::HUE_W-1:0] hue_next;
  logic [r2h_pkg::CH_W-1:0]  sat_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    unique case (in_data.sector)
      r2h_pkg::SECT_RED:   ofs = r2h_pkg::HUE_OFS_RED;
      r2h_pkg::SECT_GREEN: ofs = r2h_pkg::HUE_OFS_GREEN;
      r2h_pkg::SECT_BLUE:  ofs = r2h_pkg::HUE_OFS_BLUE;
      default:             ofs = r2h_pkg::HUE_OFS_RED;
    endcase
    // a negative numerator with a remainder floors one further down
    qmag  = {1'b0, in_data.qh} + {12'd0, (in_data.neg && (in_data.rem_h != '0))};
    hsum  = (in_data.neg ? (16'd0 - {3'd0, qmag}) : {3'd0, qmag}) + ofs;
    hwrap = hsum[15] ? (hsum + r2h_pkg::HUE_FULL) : hsum;
    hue_next = in_data.grey ? '0 : hwrap[r2h_pkg::HUE_W-1:0];
    sat_next = in_data.grey ? '0 : in_data.qs[r2h_pkg::CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue        <= hue_next;
      saturation <= sat_next;
      brightness <= in_data.mx;
      grey       <= in_data.grey;
    end
  end

endmodule

// File: rtl/rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit: pipelined RGB to HSV converter
// One pixel in, one hue/saturation/brightness result out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  pix     | in  | red[7:0] green[7:0] blue[7:0]             | valid/ready
//  hsv     | out | hue[14:0] saturation[7:0] brightness[7:0] | valid/ready
//          |     | grey                                      |
//
// Six register stages: range, dividend, three divider stages of four
// quotient bits each, and the output register. A result moves through
// them in that order; one request per cycle is taken unless hsv.ready stalls.
// Each stage holds its own valid bit and loads whenever it is empty or
// its successor moves, so a stall fills bubbles before pix.ready drops.
// Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit (
  input  logic       clk,
  input  logic       rst,
  r2h_pix_if.sink    pix,
  r2h_hsv_if.source  hsv
);

  logic          fr_valid;
  logic          d1_ready;
  r2h_pkg::div_t fr_data;
  logic          d1_valid;
  logic          d2_ready;
  r2h_pkg::div_t d1_data;
  logic          d2_valid;
  logic          d3_ready;
  r2h_pkg::div_t d2_data;
  logic          d3_valid;
  logic          hf_ready;
  r2h_pkg::div_t d3_data;

  r2h_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .red       (pix.red),
    .green     (pix.green),
    .blue      (pix.blue),
    .out_valid (fr_valid),
    .out_ready (d1_ready),
    .out_data  (fr_data)
  );

  r2h_div_stage u_div1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (d1_ready),
    .in_data   (fr_data),
    .out_valid (d1_valid),
    .out_ready (d2_ready),
    .out_data  (d1_data)
  );

  r2h_div_stage u_div2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .in_ready  (d2_ready),
    .in_data   (d1_data),
    .out_valid (d2_valid),
    .out_ready (d3_ready),
    .out_data  (d2_data)
  );

  r2h_div_stage u_div3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_valid),
    .in_ready  (d3_ready),
    .in_data   (d2_data),
    .out_valid (d3_valid),
    .out_ready (hf_ready),
    .out_data  (d3_data)
  );

  r2h_hue_fix u_hue_fix (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d3_valid),
    .in_ready   (hf_ready),
    .in_data    (d3_data),
    .out_valid  (hsv.valid),
    .out_ready  (hsv.ready),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .grey       (hsv.grey)
  );

`ifndef SYNTHESIS
  a_grey_zeroes: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && hsv.grey |-> hsv.hue == '0 && hsv.saturation == '0)
    else $error("grey result with non-zero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> hsv.hue < r2h_pkg::HUE_FULL[r2h_pkg::HUE_W-1:0])
    else $error("hue beyond full circle");

  a_black_is_grey: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && hsv.brightness == '0 |-> hsv.grey)
    else $error("black pixel not flagged grey");

  a_bubble_takes_request: assert property (@(posedge clk) disable iff (rst)
    !d1_valid && !fr_valid |-> pix.ready)
    else $error("request refused with empty front stages");
`endif

endmodule
